// ===== src/lgev_pkg.sv =====
`timescale 1ns / 1ps

package lgev_pkg;

  // Largest grid side the store is built for
  localparam int MAX_SIDE_DEFAULT = 64;

  // Request and result field widths
  localparam int FUNC_W      = 2;
  localparam int IDX_W       = 6;
  localparam int GRID_SIZE_W = 7;
  localparam int GENS_W      = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_GRID_SIZE   = 1'b0;
  localparam logic REG_GENERATIONS = 1'b1;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET   = 7'd8;
  localparam logic [GENS_W-1:0]      GENERATIONS_RESET = 16'd1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVOLVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_GEN_PRIME,
    ST_GEN_LOAD,
    ST_GEN_ROW,
    ST_POST
  } lgev_state_t;

endpackage

// ===== src/life_grid_evolver_unit.sv =====
`timescale 1ns / 1ps

// Read and write: cell state (skipped on an index error), then the post state.
// Evolve: each generation primes the window in the prime and load states, then
// sweeps one row per cycle through the single grid RAM port pair.
// One request in flight at a time; the next is accepted once the result is loaded.
// Reset: synchronous; clears all MAX_SIDE grid rows, one row a cycle,
// during which req_stall stays high; grid_size resets to 8, generations to 1.

module life_grid_evolver_unit #(
  parameter int MAX_SIDE = lgev_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lgev_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lgev_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lgev_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [lgev_pkg::FUNC_W-1:0]         func,
  input  logic [lgev_pkg::IDX_W-1:0]          row,
  input  logic [lgev_pkg::IDX_W-1:0]          col,
  input  logic                                cell_in,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                cell_out,
  output logic                                index_error
);

  // Row address into the grid RAM, and a size/row counter wide enough for MAX_SIDE
  localparam int AW   = $clog2(MAX_SIDE);
  localparam int SZ_B = $clog2(MAX_SIDE + 1);
  localparam int SZ_W = (SZ_B > lgev_pkg::GRID_SIZE_W) ? SZ_B : lgev_pkg::GRID_SIZE_W;

  lgev_pkg::lgev_state_t state, state_next;

  // Configuration registers
  logic [lgev_pkg::GRID_SIZE_W-1:0] grid_size;
  logic [lgev_pkg::GENS_W-1:0]      generations;

  // Held request
  logic [lgev_pkg::FUNC_W-1:0] req_func;
  logic [lgev_pkg::IDX_W-1:0]  req_row;
  logic [lgev_pkg::IDX_W-1:0]  req_col;
  logic                        req_cell;

  // Sweep state
  logic [SZ_W-1:0]             row_idx;
  logic [SZ_W-1:0]             row_inc;
  logic [lgev_pkg::GENS_W-1:0] gen_left;
  logic [MAX_SIDE-1:0]         up_row;
  logic [MAX_SIDE-1:0]         cur_raw;

  // Pending result
  logic pend_cell;
  logic pend_err;

  logic [SZ_W-1:0]     eff_size;
  logic [MAX_SIDE-1:0] col_mask;
  logic                idx_err;
  logic                func_is_cell;
  logic                out_free;
  logic                row_last;

  // Window for the rule
  logic [MAX_SIDE-1:0] cur_row;
  logic [MAX_SIDE-1:0] dn_row;
  logic [MAX_SIDE-1:0] nxt_row;

  // Grid RAM
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MAX_SIDE-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [MAX_SIDE-1:0] mem_rdata;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      lgev_pkg::REG_GRID_SIZE:   prdata = lgev_pkg::APB_DATA_W'(grid_size);
      lgev_pkg::REG_GENERATIONS: prdata = lgev_pkg::APB_DATA_W'(generations);
      default:                   prdata = '0;
    endcase
  end

  // Saturate the configured size at the store's side
  assign eff_size = (SZ_W'(grid_size) > SZ_W'(MAX_SIDE)) ? SZ_W'(MAX_SIDE)
                                                         : SZ_W'(grid_size);

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      col_mask[i] = SZ_W'(i) < eff_size;
    end
  end

  assign idx_err      = (SZ_W'(row) >= eff_size) || (SZ_W'(col) >= eff_size);
  assign func_is_cell = (func == lgev_pkg::FUNC_WRITE) || (func == lgev_pkg::FUNC_READ);
  assign out_free     = !rsp_valid || !rsp_stall;
  assign row_inc      = row_idx + SZ_W'(1);
  assign row_last     = row_inc == eff_size;

  // Window: current row from the snapshot, next row straight from the RAM
  // (it is written only after it has been read), dead below the grid
  assign cur_row = cur_raw & col_mask;
  assign dn_row  = row_last ? '0 : (mem_rdata & col_mask);

  lgev_row_rule #(
    .WIDTH (MAX_SIDE)
  ) u_rule (
    .up_row  (up_row),
    .mid_row (cur_row),
    .dn_row  (dn_row),
    .nxt_row (nxt_row)
  );

  lgev_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lgev_pkg::ST_CLEAR: begin
        if (row_idx == SZ_W'(MAX_SIDE - 1)) begin
          state_next = lgev_pkg::ST_IDLE;
        end
      end
      lgev_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (func_is_cell) begin
            state_next = idx_err ? lgev_pkg::ST_POST : lgev_pkg::ST_CELL;
          end else if (func == lgev_pkg::FUNC_EVOLVE && generations != '0
                       && eff_size != '0) begin
            state_next = lgev_pkg::ST_GEN_PRIME;
          end else begin
            state_next = lgev_pkg::ST_POST;
          end
        end
      end
      lgev_pkg::ST_CELL:      state_next = lgev_pkg::ST_POST;
      lgev_pkg::ST_GEN_PRIME: state_next = lgev_pkg::ST_GEN_LOAD;
      lgev_pkg::ST_GEN_LOAD:  state_next = lgev_pkg::ST_GEN_ROW;
      lgev_pkg::ST_GEN_ROW: begin
        if (row_last) begin
          state_next = (gen_left == lgev_pkg::GENS_W'(1)) ? lgev_pkg::ST_POST
                                                          : lgev_pkg::ST_GEN_PRIME;
        end
      end
      lgev_pkg::ST_POST: begin
        if (out_free) begin
          state_next = lgev_pkg::ST_IDLE;
        end
      end
      default: state_next = lgev_pkg::ST_CLEAR;
    endcase
  end

  // RAM controls and request stall
  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = AW'(row_idx);
    mem_wdata = '0;
    mem_raddr = AW'(row);
    unique case (state)
      lgev_pkg::ST_CLEAR: begin
        // wipe one row a cycle
        mem_we = 1'b1;
      end
      lgev_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      lgev_pkg::ST_CELL: begin
        // merge the written cell into the row just read
        mem_waddr = AW'(req_row);
        mem_wdata = mem_rdata;
        mem_wdata[AW'(req_col)] = req_cell;
        mem_we    = req_func == lgev_pkg::FUNC_WRITE;
      end
      lgev_pkg::ST_GEN_PRIME: begin
        mem_raddr = '0;
      end
      lgev_pkg::ST_GEN_LOAD: begin
        mem_raddr = AW'(1);
      end
      lgev_pkg::ST_GEN_ROW: begin
        // write row r, fetch row r + 2; cells right of the grid keep their values
        mem_we    = 1'b1;
        mem_wdata = (cur_raw & ~col_mask) | (nxt_row & col_mask);
        mem_raddr = AW'(row_idx + SZ_W'(2));
      end
      lgev_pkg::ST_POST: begin
        req_stall = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lgev_pkg::ST_CLEAR;
      row_idx     <= '0;
      rsp_valid   <= 1'b0;
      grid_size   <= lgev_pkg::GRID_SIZE_RESET;
      generations <= lgev_pkg::GENERATIONS_RESET;
    end else begin
      state <= state_next;

      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          lgev_pkg::REG_GRID_SIZE:
            grid_size <= pwdata[lgev_pkg::GRID_SIZE_W-1:0];
          lgev_pkg::REG_GENERATIONS:
            generations <= pwdata[lgev_pkg::GENS_W-1:0];
          default: ;
        endcase
      end

      // raise the result from the post state, drop it once taken
      if (state == lgev_pkg::ST_POST) begin
        if (out_free) begin
          rsp_valid <= 1'b1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        lgev_pkg::ST_CLEAR: begin
          row_idx <= row_inc;
        end
        lgev_pkg::ST_IDLE: begin
          if (req_valid) begin
            req_func  <= func;
            req_row   <= row;
            req_col   <= col;
            req_cell  <= cell_in;
            gen_left  <= generations;
            pend_cell <= 1'b0;
            pend_err  <= func_is_cell && idx_err;
          end
        end
        lgev_pkg::ST_CELL: begin
          if (req_func == lgev_pkg::FUNC_READ) begin
            pend_cell <= mem_rdata[AW'(req_col)];
          end
        end
        lgev_pkg::ST_GEN_PRIME: begin
          row_idx <= '0;
        end
        lgev_pkg::ST_GEN_LOAD: begin
          cur_raw <= mem_rdata;
          up_row  <= '0;
        end
        lgev_pkg::ST_GEN_ROW: begin
          // slide the window down one row
          up_row  <= cur_row;
          cur_raw <= mem_rdata;
          row_idx <= row_inc;
          if (row_last) begin
            gen_left <= gen_left - lgev_pkg::GENS_W'(1);
          end
        end
        lgev_pkg::ST_POST: begin
          if (out_free) begin
            cell_out    <= pend_cell;
            index_error <= pend_err;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/lgev_ram.sv =====
`timescale 1ns / 1ps

module lgev_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lgev_row_rule.sv =====
`timescale 1ns / 1ps

module lgev_row_rule #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] up_row,
  input  logic [WIDTH-1:0] mid_row,
  input  logic [WIDTH-1:0] dn_row,
  output logic [WIDTH-1:0] nxt_row
);

  // Pad with dead cells on both sides: no wraparound
  logic [WIDTH+1:0] up_x;
  logic [WIDTH+1:0] mid_x;
  logic [WIDTH+1:0] dn_x;

  assign up_x  = {1'b0, up_row, 1'b0};
  assign mid_x = {1'b0, mid_row, 1'b0};
  assign dn_x  = {1'b0, dn_row, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    for (int i = 0; i < WIDTH; i++) begin
      cnt = 4'(up_x[i]) + 4'(up_x[i+1]) + 4'(up_x[i+2])
          + 4'(mid_x[i]) + 4'(mid_x[i+2])
          + 4'(dn_x[i]) + 4'(dn_x[i+1]) + 4'(dn_x[i+2]);
      nxt_row[i] = (cnt == lgev_pkg::BIRTH_COUNT)
                || ((cnt == lgev_pkg::SURVIVE_COUNT) && mid_row[i]);
    end
  end

endmodule
